// ===== rtl/sia_pkg.sv =====
// Package for the slot identifier allocator: request and response payload types,
// operation and status codes, and fixed field widths.
// No dependencies.
package sia_pkg;

  localparam int SIZE_W  = 32;
  localparam int BYTES_W = 33;
  localparam int STAT_W  = 39;
  localparam int SLOT_W  = 6;
  localparam int LIVE_W  = 7;
  localparam int TOTAL_W = 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [SIZE_W-1:0] req_size;
    logic [SLOT_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [STAT_W-1:0]  bytes_outstanding;
    logic [STAT_W-1:0]  high_water;
    logic [LIVE_W-1:0]  live_count;
    logic [TOTAL_W-1:0] total_count;
  } rsp_t;

endpackage

// ===== rtl/slot_id_allocator_with_usage_stats.sv =====
// Top level of the slot identifier allocator with usage statistics.
// Depends on sia_pkg, sia_slot_mem and sia_core.
//
// A request transaction enters on in_valid/in_stall with in_payload
// (op, req_size, free_slot). Allocate takes the most recently freed slot or
// else the next never-used slot and records the size rounded up to even;
// free returns a slot to the head of the free list; clear zeroes the
// outstanding bytes, high-water mark and live count. Every request produces
// exactly one response transaction on out_valid/out_stall carrying the
// status, the granted slot and the statistics as they stand after it.
// An accepted request waits in the request register until the response
// register is free, then executes. One request per cycle is sustained
// while out_stall is low; the request executes between the request
// register and the response register, with the slot memories read ahead.
// Synchronous active-low reset empties the free list, clears busy bits,
// counters and both valid flags; the slot memories are not cleared since
// every entry is written before it is read. While out_stall holds a
// response, the request register still accepts one more transaction,
// after which in_stall rises until the response is taken.
module slot_id_allocator_with_usage_stats
  import sia_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_payload,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_payload
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int HEAD_W = $clog2(SLOTS + 1);

  logic req_valid_r, req_valid_nxt;
  req_t req_r;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_r;

  logic fire;
  logic accept;
  rsp_t rsp;

  logic               bytes_wr_en;
  logic [IDX_W-1:0]   bytes_wr_idx;
  logic [BYTES_W-1:0] bytes_wr_data;
  logic [IDX_W-1:0]   bytes_rd_idx;
  logic [BYTES_W-1:0] bytes_rd_data;
  logic               link_wr_en;
  logic [IDX_W-1:0]   link_wr_idx;
  logic [HEAD_W-1:0]  link_wr_data;
  logic [IDX_W-1:0]   link_rd_idx;
  logic [HEAD_W-1:0]  link_rd_data;

  // The held request executes when the response register is free or is
  // being emptied in this cycle.
  assign fire     = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  // The recorded size is fetched for whichever request sits in the request
  // register next cycle, so a free finds it ready when it executes.
  assign bytes_rd_idx = accept ? IDX_W'(in_payload.free_slot) : IDX_W'(req_r.free_slot);

  always_comb begin
    req_valid_nxt = accept || (req_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_payload;
    end
    if (fire) begin
      out_r <= rsp;
    end
  end

  sia_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .HEAD_W(HEAD_W)
  ) u_mem (
    .clk          (clk),
    .bytes_wr_en  (bytes_wr_en),
    .bytes_wr_idx (bytes_wr_idx),
    .bytes_wr_data(bytes_wr_data),
    .bytes_rd_idx (bytes_rd_idx),
    .bytes_rd_data(bytes_rd_data),
    .link_wr_en   (link_wr_en),
    .link_wr_idx  (link_wr_idx),
    .link_wr_data (link_wr_data),
    .link_rd_idx  (link_rd_idx),
    .link_rd_data (link_rd_data)
  );

  sia_core #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .HEAD_W(HEAD_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .req          (req_r),
    .bytes_rd     (bytes_rd_data),
    .head_link    (link_rd_data),
    .rsp          (rsp),
    .bytes_wr_en  (bytes_wr_en),
    .bytes_wr_idx (bytes_wr_idx),
    .bytes_wr_data(bytes_wr_data),
    .link_wr_en   (link_wr_en),
    .link_wr_idx  (link_wr_idx),
    .link_wr_data (link_wr_data),
    .link_rd_idx  (link_rd_idx)
  );

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

// ===== rtl/sia_slot_mem.sv =====
// Per-slot storage: recorded byte size and free-list link for every slot.
// Registered read ports with write-first forwarding. Depends on sia_pkg.
module sia_slot_mem
  import sia_pkg::*;
#(
  parameter int SLOTS  = 64,
  parameter int IDX_W  = 6,
  parameter int HEAD_W = 7
) (
  input  logic               clk,
  input  logic               bytes_wr_en,
  input  logic [IDX_W-1:0]   bytes_wr_idx,
  input  logic [BYTES_W-1:0] bytes_wr_data,
  input  logic [IDX_W-1:0]   bytes_rd_idx,
  output logic [BYTES_W-1:0] bytes_rd_data,
  input  logic               link_wr_en,
  input  logic [IDX_W-1:0]   link_wr_idx,
  input  logic [HEAD_W-1:0]  link_wr_data,
  input  logic [IDX_W-1:0]   link_rd_idx,
  output logic [HEAD_W-1:0]  link_rd_data
);

  logic [BYTES_W-1:0] bytes_mem [SLOTS];
  logic [HEAD_W-1:0]  link_mem  [SLOTS];
  logic [BYTES_W-1:0] bytes_rd_r;
  logic [HEAD_W-1:0]  link_rd_r;

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (bytes_wr_en) begin
      bytes_mem[bytes_wr_idx] <= bytes_wr_data;
    end
    if (bytes_wr_en && (bytes_wr_idx == bytes_rd_idx)) begin
      bytes_rd_r <= bytes_wr_data;
    end else begin
      bytes_rd_r <= bytes_mem[bytes_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (link_wr_en) begin
      link_mem[link_wr_idx] <= link_wr_data;
    end
    if (link_wr_en && (link_wr_idx == link_rd_idx)) begin
      link_rd_r <= link_wr_data;
    end else begin
      link_rd_r <= link_mem[link_rd_idx];
    end
  end

  assign bytes_rd_data = bytes_rd_r;
  assign link_rd_data  = link_rd_r;

endmodule

// ===== rtl/sia_core.sv =====
// Allocation state and per-transaction update: free-list head, fill mark,
// busy bits and usage counters. Depends on sia_pkg.
module sia_core
  import sia_pkg::*;
#(
  parameter int SLOTS  = 64,
  parameter int IDX_W  = 6,
  parameter int HEAD_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  req_t               req,
  input  logic [BYTES_W-1:0] bytes_rd,
  input  logic [HEAD_W-1:0]  head_link,
  output rsp_t               rsp,
  output logic               bytes_wr_en,
  output logic [IDX_W-1:0]   bytes_wr_idx,
  output logic [BYTES_W-1:0] bytes_wr_data,
  output logic               link_wr_en,
  output logic [IDX_W-1:0]   link_wr_idx,
  output logic [HEAD_W-1:0]  link_wr_data,
  output logic [IDX_W-1:0]   link_rd_idx
);

  localparam logic [HEAD_W-1:0] LIST_END = HEAD_W'(SLOTS);

  logic [HEAD_W-1:0]  head_r, head_nxt;
  logic [HEAD_W-1:0]  used_top_r, used_top_nxt;
  logic [STAT_W-1:0]  outstanding_r, outstanding_nxt;
  logic [STAT_W-1:0]  peak_r, peak_nxt;
  logic [HEAD_W-1:0]  live_r, live_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [SLOTS-1:0]   busy_r, busy_nxt;

  logic [HEAD_W-1:0]  head_calc, used_top_calc, live_calc;
  logic [STAT_W-1:0]  outstanding_calc, peak_calc;
  logic [TOTAL_W-1:0] total_calc;
  logic [SLOTS-1:0]   busy_calc;
  logic               alloc_ok, free_ok;
  status_t            status;
  logic [IDX_W-1:0]   alloc_idx;

  always_comb begin
    logic [BYTES_W-1:0] rounded;
    logic [STAT_W-1:0]  sum;
    logic [STAT_W-1:0]  bytes_ext;
    logic [IDX_W-1:0]   fidx;
    logic               fslot_ok;

    rounded          = {1'b0, req.req_size} + {{(BYTES_W-1){1'b0}}, req.req_size[0]};
    sum              = outstanding_r + STAT_W'(rounded);
    bytes_ext        = STAT_W'(bytes_rd);
    fidx             = IDX_W'(req.free_slot);
    fslot_ok         = (32'(req.free_slot) < SLOTS);

    head_calc        = head_r;
    used_top_calc    = used_top_r;
    outstanding_calc = outstanding_r;
    peak_calc        = peak_r;
    live_calc        = live_r;
    total_calc       = total_r;
    busy_calc        = busy_r;
    alloc_ok         = 1'b0;
    free_ok          = 1'b0;
    status           = ST_OK;
    alloc_idx        = '0;

    case (op_t'(req.op))
      OP_ALLOC: begin
        if (req.req_size == '0) begin
          status = ST_ZERO_SIZE;
        end else if (head_r < LIST_END) begin
          // Reuse the most recently released slot.
          alloc_ok  = 1'b1;
          alloc_idx = head_r[IDX_W-1:0];
          head_calc = (head_link > LIST_END) ? LIST_END : head_link;
        end else if (used_top_r < LIST_END) begin
          alloc_ok      = 1'b1;
          alloc_idx     = used_top_r[IDX_W-1:0];
          used_top_calc = used_top_r + HEAD_W'(1);
        end else begin
          status = ST_FULL;
        end
        if (alloc_ok) begin
          busy_calc[alloc_idx] = 1'b1;
          total_calc           = total_r + TOTAL_W'(1);
          live_calc            = live_r + HEAD_W'(1);
          outstanding_calc     = sum;
          peak_calc            = (sum > peak_r) ? sum : peak_r;
        end
      end
      OP_FREE: begin
        if (fslot_ok && busy_r[fidx]) begin
          free_ok              = 1'b1;
          busy_calc[fidx]      = 1'b0;
          head_calc            = HEAD_W'(fidx);
          // Counters saturate at zero when a clear came between alloc and free.
          outstanding_calc     = (outstanding_r >= bytes_ext) ? outstanding_r - bytes_ext : '0;
          live_calc            = (live_r != '0) ? live_r - HEAD_W'(1) : '0;
        end else begin
          status = ST_NOT_ALLOC;
        end
      end
      OP_CLEAR: begin
        outstanding_calc = '0;
        peak_calc        = '0;
        live_calc        = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head_nxt        = fire ? head_calc        : head_r;
    used_top_nxt    = fire ? used_top_calc    : used_top_r;
    outstanding_nxt = fire ? outstanding_calc : outstanding_r;
    peak_nxt        = fire ? peak_calc        : peak_r;
    live_nxt        = fire ? live_calc        : live_r;
    total_nxt       = fire ? total_calc       : total_r;
    busy_nxt        = fire ? busy_calc        : busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= LIST_END;
      used_top_r    <= '0;
      outstanding_r <= '0;
      peak_r        <= '0;
      live_r        <= '0;
      total_r       <= '0;
      busy_r        <= '0;
    end else begin
      head_r        <= head_nxt;
      used_top_r    <= used_top_nxt;
      outstanding_r <= outstanding_nxt;
      peak_r        <= peak_nxt;
      live_r        <= live_nxt;
      total_r       <= total_nxt;
      busy_r        <= busy_nxt;
    end
  end

  always_comb begin
    rsp.status            = status;
    rsp.granted_slot      = alloc_ok ? SLOT_W'(alloc_idx) : '0;
    rsp.bytes_outstanding = outstanding_calc;
    rsp.high_water        = peak_calc;
    rsp.live_count        = LIVE_W'(live_calc);
    rsp.total_count       = total_calc;
  end

  // Memory writes: record the size on allocate, link the slot in on free.
  always_comb begin
    bytes_wr_en   = fire && alloc_ok;
    bytes_wr_idx  = alloc_idx;
    bytes_wr_data = {1'b0, req.req_size} + {{(BYTES_W-1){1'b0}}, req.req_size[0]};
    link_wr_en    = fire && free_ok;
    link_wr_idx   = IDX_W'(req.free_slot);
    link_wr_data  = head_r;
    // Keep the link of the next head in the read register at all times.
    link_rd_idx   = (head_nxt < LIST_END) ? head_nxt[IDX_W-1:0] : '0;
  end

endmodule
